@@ src/xxh32_pkg.sv @@
package xxh32_pkg;

    localparam logic [31:0] PRIME_A = 32'h9E37_79B1;
    localparam logic [31:0] PRIME_B = 32'h85EB_CA77;
    localparam logic [31:0] PRIME_C = 32'hC2B2_AE3D;
    localparam logic [31:0] PRIME_D = 32'h27D4_EB2F;
    localparam logic [31:0] PRIME_E = 32'h1656_67B1;

    // Starting value of lane 0 on top of the seed
    localparam logic [31:0] LANE0_OFS = PRIME_A + PRIME_B;

    // Word index of the seed register on the configuration port
    localparam logic SEED_WORD = 1'b0;

    // Datapath operations
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_STORE     = 4'd1;
    localparam logic [3:0] OP_LANE_INIT = 4'd2;
    localparam logic [3:0] OP_MUL_WORD  = 4'd3;
    localparam logic [3:0] OP_ROUND_ADD = 4'd4;
    localparam logic [3:0] OP_MUL_LANE  = 4'd5;
    localparam logic [3:0] OP_MERGE     = 4'd6;
    localparam logic [3:0] OP_ADD_LEN   = 4'd7;
    localparam logic [3:0] OP_WORD_ADD  = 4'd8;
    localparam logic [3:0] OP_MUL_BYTE  = 4'd9;
    localparam logic [3:0] OP_BYTE_ADD  = 4'd10;
    localparam logic [3:0] OP_MUL_H     = 4'd11;
    localparam logic [3:0] OP_XS15      = 4'd12;
    localparam logic [3:0] OP_XS13      = 4'd13;
    localparam logic [3:0] OP_XS16      = 4'd14;
    localparam logic [3:0] OP_EMIT      = 4'd15;

    // Multiplier constant select
    localparam logic [2:0] K_A = 3'd0;
    localparam logic [2:0] K_B = 3'd1;
    localparam logic [2:0] K_C = 3'd2;
    localparam logic [2:0] K_D = 3'd3;
    localparam logic [2:0] K_E = 3'd4;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] idx;   // lane number or byte position
        logic [2:0] ksel;
    } cmd_t;

    typedef struct packed {
        logic [3:0] tail;      // byte count mod 16
        logic       seen;      // a full stripe went through the lanes
        logic       out_free;  // result register can load this cycle
    } status_t;

    function automatic logic [31:0] prime_of(input logic [2:0] ksel);
        logic [31:0] k;
        case (ksel)
            K_A:     k = PRIME_A;
            K_B:     k = PRIME_B;
            K_C:     k = PRIME_C;
            K_D:     k = PRIME_D;
            K_E:     k = PRIME_E;
            default: k = PRIME_A;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] r);
        logic [5:0] rr;
        rr = 6'd32 - {1'b0, r};
        return (v << r) | (v >> rr);
    endfunction

endpackage

@@ src/xxh32_ctrl.sv @@
module xxh32_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               byte_present,
    input  logic               last,
    input  xxh32_pkg::status_t status,
    output xxh32_pkg::cmd_t    cmd
);
    import xxh32_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LINIT = 4'd1;
    localparam logic [3:0] S_LANE  = 4'd2;
    localparam logic [3:0] S_MERGE = 4'd3;
    localparam logic [3:0] S_LEN   = 4'd4;
    localparam logic [3:0] S_WORD  = 4'd5;
    localparam logic [3:0] S_BYTE  = 4'd6;
    localparam logic [3:0] S_AVAL  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [3:0] idx_reg, idx_next;
    logic       last_pend_reg, last_pend_next;
    logic       accept;
    logic       word_ok;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign word_ok  = ({1'b0, idx_reg} + 5'd4) <= {1'b0, status.tail};

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        last_pend_next = last_pend_reg;
        cmd            = '{op: OP_NOP, idx: idx_reg, ksel: K_A};
        case (state_reg)
            S_IDLE: begin
                phase_next = 3'd0;
                idx_next   = 4'd0;
                if (accept) begin
                    if (byte_present) begin
                        cmd.op = OP_STORE;
                    end
                    // stripe completes with this byte
                    if (byte_present && status.tail == 4'd15) begin
                        last_pend_next = last;
                        state_next     = status.seen ? S_LANE : S_LINIT;
                    end else if (last) begin
                        state_next = S_MERGE;
                    end
                end
            end
            S_LINIT: begin
                cmd.op     = OP_LANE_INIT;
                state_next = S_LANE;
            end
            S_LANE: begin
                case (phase_reg)
                    3'd0: begin
                        cmd.op     = OP_MUL_WORD;
                        cmd.idx    = {idx_reg[1:0], 2'b00};
                        cmd.ksel   = K_B;
                        phase_next = 3'd1;
                    end
                    3'd1: begin
                        cmd.op     = OP_ROUND_ADD;
                        phase_next = 3'd2;
                    end
                    default: begin
                        cmd.op     = OP_MUL_LANE;
                        phase_next = 3'd0;
                        idx_next   = idx_reg + 4'd1;
                        if (idx_reg[1:0] == 2'd3) begin
                            idx_next   = 4'd0;
                            state_next = last_pend_reg ? S_MERGE : S_IDLE;
                        end
                    end
                endcase
            end
            S_MERGE: begin
                cmd.op     = OP_MERGE;
                state_next = S_LEN;
            end
            S_LEN: begin
                cmd.op     = OP_ADD_LEN;
                idx_next   = 4'd0;
                phase_next = 3'd0;
                state_next = S_WORD;
            end
            S_WORD: begin
                case (phase_reg)
                    3'd0: begin
                        if (word_ok) begin
                            cmd.op     = OP_MUL_WORD;
                            cmd.ksel   = K_C;
                            phase_next = 3'd1;
                        end else begin
                            state_next = S_BYTE;
                        end
                    end
                    3'd1: begin
                        cmd.op     = OP_WORD_ADD;
                        phase_next = 3'd2;
                    end
                    default: begin
                        cmd.op     = OP_MUL_H;
                        cmd.ksel   = K_D;
                        phase_next = 3'd0;
                        idx_next   = idx_reg + 4'd4;
                    end
                endcase
            end
            S_BYTE: begin
                case (phase_reg)
                    3'd0: begin
                        if (idx_reg < status.tail) begin
                            cmd.op     = OP_MUL_BYTE;
                            cmd.ksel   = K_E;
                            phase_next = 3'd1;
                        end else begin
                            state_next = S_AVAL;
                        end
                    end
                    3'd1: begin
                        cmd.op     = OP_BYTE_ADD;
                        phase_next = 3'd2;
                    end
                    default: begin
                        cmd.op     = OP_MUL_H;
                        cmd.ksel   = K_A;
                        phase_next = 3'd0;
                        idx_next   = idx_reg + 4'd1;
                    end
                endcase
            end
            S_AVAL: begin
                phase_next = phase_reg + 3'd1;
                case (phase_reg)
                    3'd0: cmd.op = OP_XS15;
                    3'd1: begin
                        cmd.op   = OP_MUL_H;
                        cmd.ksel = K_B;
                    end
                    3'd2: cmd.op = OP_XS13;
                    3'd3: begin
                        cmd.op   = OP_MUL_H;
                        cmd.ksel = K_C;
                    end
                    default: begin
                        cmd.op     = OP_XS16;
                        phase_next = 3'd0;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_OUT: begin
                // hold until the result register frees up
                if (status.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            phase_reg     <= 3'd0;
            idx_reg       <= 4'd0;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            last_pend_reg <= last_pend_next;
        end
    end

endmodule

@@ src/xxh32_dp.sv @@
module xxh32_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  xxh32_pkg::cmd_t    cmd,
    input  logic [7:0]         data_byte,
    input  logic [31:0]        seed,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [31:0]        m_tdata,
    output xxh32_pkg::status_t status
);
    import xxh32_pkg::*;

    logic [7:0]  stripe_reg [16];
    logic [31:0] lane_reg [4];
    logic [31:0] h_reg;
    logic [31:0] t_reg;
    logic [31:0] count_reg;
    logic        seen_reg;
    logic [31:0] hash_reg;
    logic        valid_reg;

    logic [1:0]  word_sel;
    logic [31:0] word_rd;
    logic [7:0]  byte_rd;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] prod;
    logic [31:0] merge_sum;
    logic        out_free;

    // one word address into the stripe; a byte is picked out of that word
    assign word_sel = cmd.idx[3:2];
    assign word_rd  = {stripe_reg[{word_sel, 2'd3}], stripe_reg[{word_sel, 2'd2}],
                       stripe_reg[{word_sel, 2'd1}], stripe_reg[{word_sel, 2'd0}]};
    always_comb begin
        case (cmd.idx[1:0])
            2'd0:    byte_rd = word_rd[7:0];
            2'd1:    byte_rd = word_rd[15:8];
            2'd2:    byte_rd = word_rd[23:16];
            default: byte_rd = word_rd[31:24];
        endcase
    end

    // shared multiplier
    always_comb begin
        case (cmd.op)
            OP_MUL_WORD: mul_a = word_rd;
            OP_MUL_BYTE: mul_a = {24'd0, byte_rd};
            default:     mul_a = h_reg;
        endcase
    end
    assign mul_b = prime_of(cmd.ksel);
    assign prod  = mul_a * mul_b;

    assign merge_sum = (rotl(lane_reg[0], 5'd1) + rotl(lane_reg[1], 5'd7))
                     + (rotl(lane_reg[2], 5'd12) + rotl(lane_reg[3], 5'd18));

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_STORE:     stripe_reg[count_reg[3:0]] <= data_byte;
            OP_LANE_INIT: begin
                lane_reg[0] <= seed + LANE0_OFS;
                lane_reg[1] <= seed + PRIME_B;
                lane_reg[2] <= seed;
                lane_reg[3] <= seed - PRIME_A;
            end
            OP_MUL_WORD:  t_reg <= prod;
            OP_MUL_BYTE:  t_reg <= prod;
            OP_ROUND_ADD: h_reg <= rotl(lane_reg[cmd.idx[1:0]] + t_reg, 5'd13);
            OP_MUL_LANE:  lane_reg[cmd.idx[1:0]] <= prod;
            OP_MERGE:     h_reg <= seen_reg ? merge_sum : seed + PRIME_E;
            OP_ADD_LEN:   h_reg <= h_reg + count_reg;
            OP_WORD_ADD:  h_reg <= rotl(h_reg + t_reg, 5'd17);
            OP_BYTE_ADD:  h_reg <= rotl(h_reg + t_reg, 5'd11);
            OP_MUL_H:     h_reg <= prod;
            OP_XS15:      h_reg <= h_reg ^ (h_reg >> 15);
            OP_XS13:      h_reg <= h_reg ^ (h_reg >> 13);
            OP_XS16:      h_reg <= h_reg ^ (h_reg >> 16);
            OP_EMIT:      hash_reg <= h_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 32'd0;
            seen_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            case (cmd.op)
                OP_STORE:     count_reg <= count_reg + 32'd1;
                OP_LANE_INIT: seen_reg  <= 1'b1;
                OP_EMIT: begin
                    count_reg <= 32'd0;
                    seen_reg  <= 1'b0;
                end
                default: ;
            endcase
            if (cmd.op == OP_EMIT) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid        = valid_reg;
    assign m_tdata         = hash_reg;
    assign status.tail     = count_reg[3:0];
    assign status.seen     = seen_reg;
    assign status.out_free = out_free;

endmodule

@@ src/xxhash32_stream_core.sv @@
// Channel  Dir  Payload                                                   Handshake
// s_       in   tdata[7:0]=data_byte, tuser=byte_present, tlast=last       tvalid/tready
// m_       out  tdata[31:0]=hash                                          tvalid/tready
// APB      in   seed at byte address 0                                    psel/penable/pready
//
// A byte that does not complete a stripe is only stored. A byte that fills a 16-byte
// stripe then runs the lane rounds (after a lane set-up on the first stripe) on the
// single shared multiplier. A last item then runs the merge, the length add, a round
// per tail word and per tail byte and the avalanche, all through the same multiplier,
// and loads the result. Input is taken while a result waits; finalization holds
// until the result register is free. Reset is synchronous, active low; no clearing pass.
module xxhash32_stream_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] hash
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import xxh32_pkg::*;

    logic [31:0] seed_reg;
    cmd_t        cmd;
    status_t     status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == SEED_WORD) ? seed_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 32'd0;
        end else if (psel && penable && pwrite && pready && paddr[2] == SEED_WORD) begin
            seed_reg <= pwdata;
        end
    end

    xxh32_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .byte_present (s_tuser),
        .last         (s_tlast),
        .status       (status),
        .cmd          (cmd)
    );

    xxh32_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .data_byte (s_tdata),
        .seed      (seed_reg),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .status    (status)
    );

endmodule

@@ src/xxh32_checker.sv @@
module xxh32_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // finalization occupies the block after the closing transaction
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during finalization");

    // an empty, non-closing transaction leaves the block ready
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && !s_tlast |=> s_tready)
        else $error("idle transaction stalled the input");

endmodule

bind xxhash32_stream_core xxh32_checker u_xxh32_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/xxhash32_stream_checker.sv @@
module xxhash32_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] hash
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          hashes_pending,
    output int          error_count
);
    import xxh32_pkg::*;

    localparam logic [2:0] SEED_ADDR = {SEED_WORD, 2'b00};

    logic [31:0] seed_q;
    logic [31:0] lane [4];
    logic [7:0]  stripe [16];
    logic [31:0] msg_len;
    logic        stripe_done;
    logic [31:0] pending_hashes [$];
    int          errors = 0;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    // Little-endian word out of the stripe buffer
    function automatic logic [31:0] stripe_word(input int pos);
        return {stripe[pos + 3], stripe[pos + 2], stripe[pos + 1], stripe[pos]};
    endfunction

    function automatic logic [31:0] lane_round(input logic [31:0] acc,
                                               input logic [31:0] w);
        logic [31:0] t;
        t = acc + w * PRIME_B;
        t = rol32(t, 13);
        return t * PRIME_A;
    endfunction

    function automatic logic [31:0] finish_hash();
        logic [31:0] h;
        int          tail;
        int          pos;
        tail = int'(msg_len[3:0]);
        pos  = 0;
        if (stripe_done) begin
            h = rol32(lane[0], 1) + rol32(lane[1], 7) + rol32(lane[2], 12)
              + rol32(lane[3], 18);
        end else begin
            h = seed_q + PRIME_E;
        end
        h = h + msg_len;
        while (pos + 4 <= tail) begin
            h = h + stripe_word(pos) * PRIME_C;
            h = rol32(h, 17) * PRIME_D;
            pos += 4;
        end
        while (pos < tail) begin
            h = h + stripe[pos] * PRIME_E;
            h = rol32(h, 11) * PRIME_A;
            pos++;
        end
        h = h ^ (h >> 15);
        h = h * PRIME_B;
        h = h ^ (h >> 13);
        h = h * PRIME_C;
        h = h ^ (h >> 16);
        return h;
    endfunction

    task automatic take_item(input logic [7:0] b, input logic present, input logic is_last);
        logic [3:0] pos;
        int         i;
        if (present) begin
            pos = msg_len[3:0];
            stripe[pos] = b;
            msg_len = msg_len + 1;
            if (pos == 4'd15) begin
                // lanes pick up the seed on the first full stripe only
                if (!stripe_done) begin
                    lane[0] = seed_q + LANE0_OFS;
                    lane[1] = seed_q + PRIME_B;
                    lane[2] = seed_q;
                    lane[3] = seed_q - PRIME_A;
                end
                for (i = 0; i < 4; i++)
                    lane[i] = lane_round(lane[i], stripe_word(4 * i));
                stripe_done = 1'b1;
            end
        end
        if (is_last) begin
            pending_hashes.push_back(finish_hash());
            msg_len     = '0;
            stripe_done = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            seed_q      = '0;
            msg_len     = '0;
            stripe_done = 1'b0;
            for (int i = 0; i < 4; i++)
                lane[i] = '0;
            for (int i = 0; i < 16; i++)
                stripe[i] = '0;
            pending_hashes.delete();
            hashes_pending <= 0;
            error_count    <= errors;
        end else begin
            if (psel && penable && pready && paddr == SEED_ADDR) begin
                if (pwrite) begin
                    seed_q = pwdata;
                end else if (prdata !== seed_q) begin
                    $error("seed readback: expected %h, actual %h", seed_q, prdata);
                    errors++;
                end
            end
            if (m_tvalid && m_tready) begin
                if (pending_hashes.size() == 0) begin
                    $error("hash: expected none, actual %h", m_tdata);
                    errors++;
                end else begin
                    want = pending_hashes.pop_front();
                    if (m_tdata !== want) begin
                        $error("hash: expected %h, actual %h", want, m_tdata);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_item(s_tdata, s_tuser, s_tlast);
            hashes_pending <= pending_hashes.size();
            error_count    <= errors;
        end
    end

endmodule

@@ tb/sv/tb_xxhash32_stream_core.sv @@
module tb_xxhash32_stream_core;
    import xxh32_pkg::*;

    localparam logic [2:0] SEED_ADDR = {SEED_WORD, 2'b00};
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE_WAIT = 60;
    localparam int PHASE_ITEMS = 270;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int hashes_pending;
    int error_count;

    logic quiet           = 1'b0;
    logic long_hold_req   = 1'b0;
    logic long_hold_taken = 1'b0;
    logic rx_calm         = 1'b0;
    int   hold_left       = 0;
    int   rx_mode_left    = 0;
    bit   tx_bursty;

    int n_msgs    = 0;
    int n_bytes   = 0;
    int n_idle    = 0;
    int n_seeds   = 1;
    int longest   = 0;
    int phase_cnt = 0;

    always #5 aclk = ~aclk;

    xxhash32_stream_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    xxhash32_stream_checker hash_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .hashes_pending(hashes_pending), .error_count(error_count)
    );

    // Result side: random stalls, calm stretches, and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_req && !long_hold_taken) begin
            long_hold_taken <= 1'b1;
            hold_left       <= LONG_HOLD - 1;
            m_tready        <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_calm      <= ($urandom_range(0, 2) == 0);
                rx_mode_left <= $urandom_range(50, 300);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            if (!rx_calm && $urandom_range(0, 5) == 0) begin
                m_tready  <= 1'b0;
                hold_left <= $urandom_range(0, 10);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic present, input logic is_last);
        int gap;
        if (!quiet && tx_bursty && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= present;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        if (present)
            n_bytes++;
        else if (!is_last)
            n_idle++;
        if (present || is_last)
            phase_cnt++;
    endtask

    task automatic send_message(input int len, input bit last_has_byte);
        int i;
        tx_bursty = ($urandom_range(0, 2) != 0);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, last_has_byte && i == len - 1);
        end
        if (!last_has_byte || len == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        n_msgs++;
        if (len > longest)
            longest = len;
    endtask

    // Drain all pending hashes, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (hashes_pending != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= SEED_ADDR;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [31:0] seeds [6];
        int          p;
        int          len;
        int          r;
        seeds[0] = 32'hFFFF_FFFF;
        seeds[1] = 32'h0000_0000;
        seeds[2] = $urandom;
        seeds[3] = 32'h8000_0000;
        seeds[4] = $urandom;
        seeds[5] = 32'h0000_0001;
        tx_bursty = 1'b0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty message, single bytes at both extremes, an idle
        // item, a last without a byte, and one exact stripe
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'hC3, 1'b0, 1'b1);
        for (int i = 0; i < 16; i++)
            send_item(8'hFF, 1'b1, i == 15);
        n_msgs += 4;
        longest = 16;

        for (p = 0; p < 6; p++) begin
            settle();
            apb_access(1'b1, seeds[p]);
            apb_access(1'b0, '0);
            n_seeds++;
            if (p == 2)
                long_hold_req <= 1'b1;
            if (p == 5)
                quiet <= 1'b1;
            phase_cnt = 0;
            while (phase_cnt < PHASE_ITEMS) begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    len = $urandom_range(0, 15);
                else if (r < 9)
                    len = $urandom_range(16, 40);
                else
                    len = $urandom_range(41, 80);
                send_message(len, $urandom_range(0, 9) < 7);
            end
        end

        settle();
        $display("covered %0d messages, %0d bytes, %0d idle items, longest %0d bytes",
                 n_msgs, n_bytes, n_idle, longest);
        $display("used %0d seed values incl. all-zero and all-one, one %0d-cycle output stall",
                 n_seeds, LONG_HOLD);
        if (error_count == 0 && hashes_pending == 0) begin
            $display("tb_xxhash32_stream_core: clean");
        end else begin
            $display("tb_xxhash32_stream_core: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d hashes outstanding", hashes_pending);
        $display("tb_xxhash32_stream_core: errors");
        $finish;
    end

endmodule
